[hdl/tdq_pkg.sv]
// Shared types and constants for the timer deadline queue.
// Used by tdq_cell and timer_deadline_queue_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdq_pkg;

   // field widths
   localparam int SLOT_W   = 4;
   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 20;
   localparam int COUNT_W  = 5;
   localparam int NEXT_W   = 30;
   localparam int SPREAD_W = 10;
   localparam int PROD_W   = 30;

   // at most this many expiry words per tick
   localparam int RESULT_LIMIT = 16;

   localparam logic [SPREAD_W-1:0] SPREAD_LAST = 10'd999;
   localparam logic [NEXT_W-1:0]   NEXT_MAX    = 30'd1048575999;
   localparam logic [PROD_W-1:0]   MS_TO_US    = 30'd1000;

   typedef enum logic [1:0] {
      CMD_ARM    = 2'd0,
      CMD_DISARM = 2'd1,
      CMD_REARM  = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE,
      ST_SCAN,
      ST_EVAL
   } state_type;

   // update broadcast to every slot cell
   typedef struct packed {
      logic              arm;
      logic              clear;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] deadline;
   } cell_op_type;

   // running minimum and armed count passed down the chain
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [TIME_W-1:0]  deadline;
      logic [COUNT_W-1:0] count;
   } cand_type;

endpackage

`default_nettype wire

[hdl/tdq_cell.sv]
// One timer slot of the deadline chain: holds armed flag and deadline, and
// merges itself into the running minimum handed on from the previous slot.
// Depends on tdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdq_cell #(
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tdq_pkg::cell_op_type op,
   input  wire tdq_pkg::cand_type    cand_prev,
   output tdq_pkg::cand_type         cand_out
);

   localparam int SW        = tdq_pkg::SLOT_W;
   localparam int CW        = tdq_pkg::COUNT_W;
   localparam int TW        = tdq_pkg::TIME_W;
   localparam int SLOT_SPAN = 2 ** SW;
   localparam bit REACHABLE = (INDEX < SLOT_SPAN);
   localparam logic [SW-1:0] OWN_SLOT = SW'(INDEX % SLOT_SPAN);

   logic              hit;
   logic              armed_ff;
   logic              armed_in;
   logic [TW-1:0]     deadline_ff;
   tdq_pkg::cand_type cand_ff;
   tdq_pkg::cand_type cand_in;

   // slots beyond the slot_id range can never be addressed
   assign hit = REACHABLE && (op.slot == OWN_SLOT);

   // arm wins over clear; arming an armed slot just rewrites it
   always_comb begin
      armed_in = armed_ff;
      if (hit && op.arm) begin
         armed_in = 1'b1;
      end else if (hit && op.clear) begin
         armed_in = 1'b0;
      end
   end

   // strict compare keeps the lower slot on equal deadlines
   always_comb begin
      cand_in       = cand_prev;
      cand_in.count = cand_prev.count + CW'(armed_ff);
      if (armed_ff && (!cand_prev.valid || (deadline_ff < cand_prev.deadline))) begin
         cand_in.valid    = 1'b1;
         cand_in.slot     = OWN_SLOT;
         cand_in.deadline = deadline_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         cand_ff  <= '0;
      end else begin
         armed_ff <= armed_in;
         cand_ff  <= cand_in;
      end
   end

   // deadline store, undefined until armed
   always_ff @(posedge clock) begin
      if (hit && op.arm) begin
         deadline_ff <= op.deadline;
      end
   end

   assign cand_out = cand_ff;

endmodule

`default_nettype wire

[hdl/timer_deadline_queue_core.sv]
// Timer deadline queue top level: command sequencer, deadline arithmetic,
// output word register and the chain of tdq_cell slots. Depends on tdq_pkg.
//
//   port group | direction | handshake            | word
//   req_       | in        | req_valid/req_ready  | command, slot_id, delay_ms, now_us
//   rsp_       | out       | rsp_valid/rsp_ready  | fired, expired_slot, last,
//              |           |                      | armed_count, next_delay_us
//
// Arm, disarm and re-arm pass through the MUL, WRITE, SCAN and EVAL states; EVAL loads the word.
// A tick scans the slot chain once, and once more after each slot that it clears, before its final
// word goes out; every minimum search is one pass of the slot chain, one slot per cycle.
// One command is processed at a time; req_ready is high only when idle, and a
// new command is taken while the final word still waits in the output register.
// A stalled rsp_ready holds the sequencer before the next word is loaded.
// Synchronous active-high reset clears all slots, the time stamp and spread counter.
`timescale 1ns / 1ps
`default_nettype none

module timer_deadline_queue_core #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [3:0]  req_slot_id,
   input  wire logic [19:0] req_delay_ms,
   input  wire logic [47:0] req_now_us,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_fired,
   output logic [3:0]       rsp_expired_slot,
   output logic             rsp_last,
   output logic [4:0]       rsp_armed_count,
   output logic [29:0]      rsp_next_delay_us
);

   localparam int SW     = tdq_pkg::SLOT_W;
   localparam int TW     = tdq_pkg::TIME_W;
   localparam int DW     = tdq_pkg::DELAY_W;
   localparam int CW     = tdq_pkg::COUNT_W;
   localparam int NW     = tdq_pkg::NEXT_W;
   localparam int PW     = tdq_pkg::PROD_W;
   localparam int XW     = tdq_pkg::SPREAD_W;
   localparam int SCAN_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int KW     = $clog2(tdq_pkg::RESULT_LIMIT);

   tdq_pkg::state_type state_ff, state_in;

   tdq_pkg::cmd_type  cmd_ff;
   logic [SW-1:0]     slot_ff;
   logic [DW-1:0]     ms_ff;
   logic [TW-1:0]     stamp_ff;
   logic [XW-1:0]     spread_ff;
   logic [PW-1:0]     prod_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [KW-1:0]     fired_n_ff;
   logic              pend_ff;
   logic [SW-1:0]     pend_slot_ff;

   logic              rsp_valid_ff;
   logic              rsp_fired_ff;
   logic [SW-1:0]     rsp_slot_ff;
   logic              rsp_last_ff;
   logic [CW-1:0]     rsp_count_ff;
   logic [NW-1:0]     rsp_delay_ff;

   logic              accept;
   logic              can_emit;
   logic              is_tick;
   logic              in_range;
   logic              expired;
   logic [TW:0]       arm_sum;
   logic [TW-1:0]     arm_deadline;
   logic [TW:0]       diff;
   logic [NW-1:0]     next_delay;

   tdq_pkg::cell_op_type op;
   logic                 do_emit;
   logic                 do_clear;
   logic                 emit_fired;
   logic                 emit_last;

   tdq_pkg::cand_type chain [TIMER_SLOTS+1];
   tdq_pkg::cand_type tail;

   // slot chain: minimum and count ripple one slot per cycle
   assign chain[0] = '0;

   for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_slot
      tdq_cell #(
         .INDEX (i)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .cand_prev (chain[i]),
         .cand_out  (chain[i+1])
      );
   end

   assign tail = chain[TIMER_SLOTS];

   // command decode
   assign accept   = req_valid && req_ready;
   assign can_emit = !rsp_valid_ff || rsp_ready;
   assign is_tick  = (cmd_ff == tdq_pkg::CMD_TICK);
   assign in_range = (32'(slot_ff) < TIMER_SLOTS);

   // deadline = stamp + ms * 1000 + spread, saturating at 48 bits
   assign arm_sum      = {1'b0, stamp_ff} + (TW+1)'(prod_ff) + (TW+1)'(spread_ff);
   assign arm_deadline = arm_sum[TW] ? {TW{1'b1}} : arm_sum[TW-1:0];

   // earliest deadline versus stamp
   assign expired = tail.valid && (tail.deadline <= stamp_ff);
   assign diff    = {1'b0, tail.deadline} - {1'b0, stamp_ff};

   always_comb begin
      if (!tail.valid || (tail.deadline <= stamp_ff)) begin
         next_delay = '0;
      end else if (diff[TW-1:0] > TW'(tdq_pkg::NEXT_MAX)) begin
         next_delay = tdq_pkg::NEXT_MAX;
      end else begin
         next_delay = diff[NW-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tdq_pkg::ST_MUL;
            end
         end
         tdq_pkg::ST_MUL: begin
            state_in = tdq_pkg::ST_WRITE;
         end
         tdq_pkg::ST_WRITE: begin
            state_in = tdq_pkg::ST_SCAN;
         end
         tdq_pkg::ST_SCAN: begin
            if (scan_ff == '0) begin
               state_in = tdq_pkg::ST_EVAL;
            end
         end
         tdq_pkg::ST_EVAL: begin
            if (can_emit) begin
               state_in = do_clear ? tdq_pkg::ST_SCAN : tdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs: slot updates and output word loads
   always_comb begin
      op         = '0;
      do_emit    = 1'b0;
      do_clear   = 1'b0;
      emit_fired = 1'b0;
      emit_last  = 1'b1;
      case (state_ff)
         tdq_pkg::ST_WRITE: begin
            op.slot     = slot_ff;
            op.deadline = arm_deadline;
            op.arm      = in_range && !is_tick && (cmd_ff != tdq_pkg::CMD_DISARM);
            op.clear    = in_range && (cmd_ff == tdq_pkg::CMD_DISARM);
         end
         tdq_pkg::ST_EVAL: begin
            if (can_emit) begin
               if (!is_tick) begin
                  do_emit = 1'b1;
               end else if (!pend_ff) begin
                  // first expired slot is cleared before its word goes out
                  do_clear = expired;
                  do_emit  = !expired;
               end else begin
                  do_emit    = 1'b1;
                  emit_fired = 1'b1;
                  do_clear   = expired && (fired_n_ff != KW'(tdq_pkg::RESULT_LIMIT - 1));
                  emit_last  = !do_clear;
               end
               op.clear = do_clear;
               op.slot  = tail.slot;
            end
         end
         default: begin
            op = '0;
         end
      endcase
   end

   // sequencer state and command registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tdq_pkg::ST_IDLE;
         stamp_ff   <= '0;
         spread_ff  <= '0;
         pend_ff    <= 1'b0;
         fired_n_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pend_ff    <= 1'b0;
            fired_n_ff <= '0;
            if (tdq_pkg::cmd_type'(req_command) == tdq_pkg::CMD_TICK) begin
               stamp_ff <= req_now_us;
            end
         end
         if (op.arm) begin
            spread_ff <= (spread_ff == tdq_pkg::SPREAD_LAST) ? '0 : spread_ff + 1'b1;
         end
         if (do_clear) begin
            pend_ff <= 1'b1;
         end
         if (do_emit && emit_fired) begin
            fired_n_ff <= fired_n_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= tdq_pkg::cmd_type'(req_command);
         slot_ff <= req_slot_id;
         ms_ff   <= req_delay_ms;
      end
      if (state_ff == tdq_pkg::ST_MUL) begin
         prod_ff <= PW'(ms_ff) * tdq_pkg::MS_TO_US;
      end
      if ((state_ff == tdq_pkg::ST_WRITE) || do_clear) begin
         scan_ff <= SCAN_W'(TIMER_SLOTS - 1);
      end else if (state_ff == tdq_pkg::ST_SCAN) begin
         scan_ff <= scan_ff - 1'b1;
      end
      if (do_clear) begin
         pend_slot_ff <= tail.slot;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) begin
         rsp_fired_ff <= emit_fired;
         rsp_slot_ff  <= emit_fired ? pend_slot_ff : '0;
         rsp_last_ff  <= emit_last;
         rsp_count_ff <= tail.count;
         rsp_delay_ff <= next_delay;
      end
   end

   assign req_ready         = (state_ff == tdq_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_expired_slot  = rsp_slot_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_armed_count   = rsp_count_ff;
   assign rsp_next_delay_us = rsp_delay_ff;

endmodule

`default_nettype wire

[hdl/tdq_checker.sv]
// Port-level assertions for timer_deadline_queue_core, with the bind that
// attaches them. Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module tdq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_fired,
   input wire logic [3:0]  rsp_expired_slot,
   input wire logic        rsp_last,
   input wire logic [4:0]  rsp_armed_count,
   input wire logic [29:0] rsp_next_delay_us
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_fired, rsp_expired_slot,
         rsp_last, rsp_armed_count, rsp_next_delay_us}))
      else $error("rsp word changed while stalled");

   // a word without expiry is always the only one and names no slot
   a_idle_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && (rsp_expired_slot == 4'd0))
      else $error("non-fired word not final or slot not zero");

   // no new command while a tick still has words to send
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("command accepted in the middle of a tick");

   // count never exceeds the addressable slots
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_armed_count <= 5'd16))
      else $error("armed count out of range");

   // nothing armed means no pending delay
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_armed_count == 5'd0) |-> (rsp_next_delay_us == 30'd0))
      else $error("delay reported with no timer armed");

endmodule

bind timer_deadline_queue_core tdq_checker u_tdq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_fired         (rsp_fired),
   .rsp_expired_slot  (rsp_expired_slot),
   .rsp_last          (rsp_last),
   .rsp_armed_count   (rsp_armed_count),
   .rsp_next_delay_us (rsp_next_delay_us)
);

`default_nettype wire
